FILE: design/ccdc_pkg.sv
`default_nettype none

package ccdc_pkg;

   // Table size bounds.
   localparam int DEFAULT_SLOTS = 16;
   localparam int MAX_SLOTS = 64;

   // Item modes.
   localparam logic [1:0] MODE_BYTE  = 2'd0;
   localparam logic [1:0] MODE_CLEAR = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   // Result kinds.
   localparam logic KIND_COMMAND = 1'b0;
   localparam logic KIND_READ    = 1'b1;

   // Header byte offsets within a command.
   localparam logic [8:0] POS_LENGTH    = 9'd1;
   localparam logic [8:0] POS_COMMAND   = 9'd2;
   localparam logic [8:0] POS_CATEGORY  = 9'd4;
   localparam logic [8:0] POS_PARAMETER = 9'd5;
   localparam logic [8:0] POS_DTYPE     = 9'd6;
   localparam logic [8:0] POS_OPERATION = 9'd7;
   localparam logic [8:0] POS_VALUE     = 9'd8;
   localparam logic [8:0] POS_LIMIT     = 9'd260;

   // Framing constants.
   localparam logic [7:0] MIN_LENGTH   = 8'd4;
   localparam logic [9:0] HEADER_BYTES = 10'd4;
   localparam logic [9:0] PAD_ROUND    = 10'd3;

   // Transport-mode update signature.
   localparam logic [7:0] XPORT_COMMAND    = 8'd0;
   localparam logic [7:0] XPORT_CATEGORY   = 8'd10;
   localparam logic [7:0] XPORT_PARAMETER  = 8'd1;
   localparam logic [7:0] XPORT_DTYPE      = 8'd1;
   localparam logic [7:0] XPORT_OPERATION  = 8'd0;
   localparam logic [7:0] XPORT_MIN_LENGTH = 8'd5;
   localparam logic [7:0] XPORT_VALUE_ON   = 8'd2;

   // Signature key of one command.
   typedef struct packed {
      logic [7:0] command;
      logic [7:0] category;
      logic [7:0] parameter_code;
      logic [7:0] dtype;
      logic [7:0] operation;
   } key_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic take;
      logic scan_issue;
      logic commit;
      logic report;
   } ctrl_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic rec_now;
      logic read_req;
      logic scan_last;
      logic out_free;
   } ctrl_status_type;

   // One result item.
   typedef struct packed {
      logic        kind;
      logic [5:0]  slot;
      logic        used;
      key_type     key;
      logic [31:0] hit_count;
      logic [31:0] last_seen;
      logic        recording;
      logic        xport;
   } rsp_type;

endpackage

`default_nettype wire

FILE: design/ccdc_ctrl.sv
`default_nettype none

module ccdc_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire ccdc_pkg::ctrl_status_type  status,
   output ccdc_pkg::ctrl_cmd_type          cmd
);

   typedef enum logic [2:0] {
      IDLE,
      SCAN,
      DRAIN,
      COMMIT,
      READ,
      REPORT
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff;

   assign req_ready = req_ready_ff;

   // Commands follow the state.
   always_comb begin
      cmd            = '0;
      cmd.take       = req_valid && req_ready_ff;
      cmd.scan_issue = (state_ff == SCAN);
      cmd.commit     = (state_ff == COMMIT);
      cmd.report     = (state_ff == REPORT);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         IDLE: begin
            if (cmd.take && status.rec_now) begin
               state_in = SCAN;
            end else if (cmd.take && status.read_req) begin
               state_in = READ;
            end
         end
         SCAN: begin
            if (status.scan_last) begin
               state_in = DRAIN;
            end
         end
         DRAIN: begin
            state_in = COMMIT;
         end
         COMMIT: begin
            if (status.out_free) begin
               state_in = IDLE;
            end
         end
         READ: begin
            state_in = REPORT;
         end
         REPORT: begin
            if (status.out_free) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // State and the registered ready.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         req_ready_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == IDLE);
      end
   end

endmodule

`default_nettype wire

FILE: design/ccdc_datapath.sv
`default_nettype none

module ccdc_datapath #(
   parameter int SLOTS = ccdc_pkg::DEFAULT_SLOTS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [1:0]                 req_mode,
   input  wire logic [7:0]                 req_byte_value,
   input  wire logic                       req_last_byte,
   input  wire logic [5:0]                 req_slot_select,
   input  wire ccdc_pkg::ctrl_cmd_type     cmd,
   output ccdc_pkg::ctrl_status_type       status,
   input  wire logic                       rsp_ready,
   output logic                            rsp_valid,
   output ccdc_pkg::rsp_type               rsp
);

   localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SLOTS - 1);
   localparam logic [6:0] SLOT_LIMIT = 7'(SLOTS);

   typedef struct packed {
      ccdc_pkg::key_type key;
      logic [31:0]       count;
      logic [31:0]       seen;
   } entry_type;

   // Table memory with per-slot valid bits.
   entry_type        mem [SLOTS];
   logic [SLOTS-1:0] valid_ff;
   entry_type        rd_data_ff;
   logic             rd_used_ff;
   logic [IDXW-1:0]  rd_addr;

   // Parser state.
   logic [8:0]        pos_ff;
   logic              stopped_ff;
   logic              start_ff;
   logic              clear_pend_ff;
   logic              rec_ff;
   logic [31:0]       seq_ff;
   logic [7:0]        length_ff;
   logic [7:0]        value_ff;
   ccdc_pkg::key_type key_ff;
   logic [5:0]        read_slot_ff;

   // Scan trackers.
   logic [IDXW-1:0] scan_idx_ff;
   logic            cmp_valid_ff;
   logic [IDXW-1:0] cmp_idx_ff;
   logic            hit_found_ff;
   logic [IDXW-1:0] hit_idx_ff;
   logic [31:0]     hit_cnt_ff;
   logic            free_found_ff;
   logic [IDXW-1:0] free_idx_ff;
   logic [IDXW-1:0] min_idx_ff;
   logic [31:0]     min_val_ff;

   // Output register.
   logic               rsp_valid_ff;
   ccdc_pkg::rsp_type  rsp_ff;

   logic              take_byte;
   logic              stop_now;
   logic [7:0]        len_eff;
   logic [9:0]        padded;
   logic [8:0]        pos_inc;
   logic              rec_cond;
   logic              match;
   logic [IDXW-1:0]   pick;
   logic [31:0]       new_count;
   logic [31:0]       new_seen;
   logic              xport;
   logic              rec_next;
   logic              commit_fire;
   logic              report_fire;
   logic              read_ok;
   ccdc_pkg::key_type xport_key;

   // Byte framing decode.
   always_comb begin
      take_byte = cmd.take && (req_mode == ccdc_pkg::MODE_BYTE);
      len_eff   = (pos_ff == ccdc_pkg::POS_LENGTH) ? req_byte_value : length_ff;
      stop_now  = (pos_ff == ccdc_pkg::POS_LENGTH) && (req_byte_value < ccdc_pkg::MIN_LENGTH);
      padded    = ({2'b00, len_eff} + ccdc_pkg::HEADER_BYTES + ccdc_pkg::PAD_ROUND)
                  & ~ccdc_pkg::PAD_ROUND;
      pos_inc   = pos_ff + 9'd1;
      // The last byte of a command sits at offset length plus three.
      rec_cond  = !stopped_ff && (pos_ff >= ccdc_pkg::POS_COMMAND) &&
                  ({1'b0, pos_ff} == ({2'b00, length_ff} + ccdc_pkg::PAD_ROUND));
   end

   // Status toward the controller.
   always_comb begin
      status           = '0;
      status.rec_now   = (req_mode == ccdc_pkg::MODE_BYTE) && rec_cond;
      status.read_req  = (req_mode == ccdc_pkg::MODE_READ);
      status.scan_last = (scan_idx_ff == LAST_IDX);
      status.out_free  = !rsp_valid_ff || rsp_ready;
   end

   // Slot choice and the updated entry.
   always_comb begin
      xport_key                = '0;
      xport_key.command        = ccdc_pkg::XPORT_COMMAND;
      xport_key.category       = ccdc_pkg::XPORT_CATEGORY;
      xport_key.parameter_code = ccdc_pkg::XPORT_PARAMETER;
      xport_key.dtype          = ccdc_pkg::XPORT_DTYPE;
      xport_key.operation      = ccdc_pkg::XPORT_OPERATION;
      if (hit_found_ff) begin
         pick = hit_idx_ff;
      end else if (free_found_ff) begin
         pick = free_idx_ff;
      end else begin
         pick = min_idx_ff;
      end
      new_count   = (hit_found_ff ? hit_cnt_ff : 32'd0) + 32'd1;
      new_seen    = seq_ff + 32'd1;
      xport       = (key_ff == xport_key) && (length_ff >= ccdc_pkg::XPORT_MIN_LENGTH);
      rec_next    = xport ? (value_ff == ccdc_pkg::XPORT_VALUE_ON) : rec_ff;
      commit_fire = cmd.commit && status.out_free;
      report_fire = cmd.report && status.out_free;
      read_ok     = ({1'b0, read_slot_ff} < SLOT_LIMIT);
      match       = rd_used_ff && (rd_data_ff.key == key_ff);
      rd_addr     = cmd.scan_issue ? scan_idx_ff : read_slot_ff[IDXW-1:0];
   end

   // Control state: framing, clear request, table valid bits, sequence.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         stopped_ff    <= 1'b0;
         start_ff      <= 1'b1;
         clear_pend_ff <= 1'b0;
         rec_ff        <= 1'b0;
         seq_ff        <= '0;
         valid_ff      <= '0;
         cmp_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.take && (req_mode == ccdc_pkg::MODE_CLEAR)) begin
            clear_pend_ff <= 1'b1;
         end
         if (take_byte) begin
            // A held clear takes effect on the first byte of a notification.
            if (start_ff && clear_pend_ff) begin
               clear_pend_ff <= 1'b0;
               valid_ff      <= '0;
               seq_ff        <= '0;
            end
            if (!stopped_ff) begin
               if (stop_now) begin
                  stopped_ff <= 1'b1;
               end else if ((pos_ff >= ccdc_pkg::POS_LENGTH) && ({1'b0, pos_inc} >= padded)) begin
                  pos_ff <= '0;
               end else begin
                  pos_ff <= pos_inc;
               end
            end
            if (req_last_byte) begin
               pos_ff     <= '0;
               stopped_ff <= 1'b0;
               start_ff   <= 1'b1;
            end else begin
               start_ff <= 1'b0;
            end
         end
         if (commit_fire) begin
            valid_ff[pick] <= 1'b1;
            seq_ff         <= new_seen;
            rec_ff         <= rec_next;
         end
         cmp_valid_ff <= cmd.scan_issue;
         if (commit_fire || report_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Header capture.
   always_ff @(posedge clock) begin
      if (take_byte && !stopped_ff) begin
         case (pos_ff)
            ccdc_pkg::POS_LENGTH:    length_ff              <= req_byte_value;
            ccdc_pkg::POS_COMMAND:   key_ff.command         <= req_byte_value;
            ccdc_pkg::POS_CATEGORY:  key_ff.category        <= req_byte_value;
            ccdc_pkg::POS_PARAMETER: key_ff.parameter_code  <= req_byte_value;
            ccdc_pkg::POS_DTYPE:     key_ff.dtype           <= req_byte_value;
            ccdc_pkg::POS_OPERATION: key_ff.operation       <= req_byte_value;
            ccdc_pkg::POS_VALUE:     value_ff               <= req_byte_value;
            default: begin
            end
         endcase
      end
      if (cmd.take && (req_mode == ccdc_pkg::MODE_READ)) begin
         read_slot_ff <= req_slot_select;
      end
   end

   // Table memory: one registered read port, one write port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      rd_used_ff <= valid_ff[rd_addr];
      if (commit_fire) begin
         mem[pick] <= '{key: key_ff, count: new_count, seen: new_seen};
      end
   end

   // Slot scan: first hit, first free slot, first lowest last-seen.
   always_ff @(posedge clock) begin
      if (cmd.take && status.rec_now) begin
         scan_idx_ff   <= '0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end
      if (cmd.scan_issue) begin
         scan_idx_ff <= scan_idx_ff + IDXW'(1);
      end
      cmp_idx_ff <= scan_idx_ff;
      if (cmp_valid_ff) begin
         if (match && !hit_found_ff) begin
            hit_found_ff <= 1'b1;
            hit_idx_ff   <= cmp_idx_ff;
            hit_cnt_ff   <= rd_data_ff.count;
         end
         if (!rd_used_ff && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= cmp_idx_ff;
         end
         if ((cmp_idx_ff == '0) || (rd_data_ff.seen < min_val_ff)) begin
            min_idx_ff <= cmp_idx_ff;
            min_val_ff <= rd_data_ff.seen;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (commit_fire) begin
         rsp_ff.kind      <= ccdc_pkg::KIND_COMMAND;
         rsp_ff.slot      <= 6'(pick);
         rsp_ff.used      <= 1'b1;
         rsp_ff.key       <= key_ff;
         rsp_ff.hit_count <= new_count;
         rsp_ff.last_seen <= new_seen;
         rsp_ff.recording <= rec_next;
         rsp_ff.xport     <= xport;
      end else if (report_fire) begin
         rsp_ff.kind      <= ccdc_pkg::KIND_READ;
         rsp_ff.slot      <= read_slot_ff;
         rsp_ff.used      <= read_ok && rd_used_ff;
         rsp_ff.key       <= (read_ok && rd_used_ff) ? rd_data_ff.key : '0;
         rsp_ff.hit_count <= (read_ok && rd_used_ff) ? rd_data_ff.count : 32'd0;
         rsp_ff.last_seen <= (read_ok && rd_used_ff) ? rd_data_ff.seen : 32'd0;
         rsp_ff.recording <= rec_ff;
         rsp_ff.xport     <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // The byte position never runs past the longest padded command.
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff < ccdc_pkg::POS_LIMIT)
      else $error("byte position out of range");

   // The scan pipeline has drained before a slot is committed.
   a_scan_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !cmp_valid_ff && !cmd.scan_issue)
      else $error("commit while scan still in flight");

   // A commit marks its slot used and advances the sequence by one.
   a_commit_effect: assert property (@(posedge clock) disable iff (reset)
      commit_fire |=> valid_ff[$past(pick)] && (seq_ff == $past(seq_ff) + 32'd1))
      else $error("commit did not update slot or sequence");

endmodule

`default_nettype wire

FILE: design/control_command_deframer_with_capture.sv
// Command deframer with signature capture.
//
// Input channel (req_): one item per handshake. Mode 0 carries one
// notification byte (req_last_byte marks the notification's end), mode 1
// requests a table clear, which takes effect on the first byte of the next
// notification, and mode 2 reads one table slot. Mode 3 is ignored.
// Result channel (rsp_): one item per completed command and per read.
//
// A byte that does not finish a command is taken while the block is
// idle, so such bytes can stream at one per cycle. The byte that finishes
// a command starts a scan of the table through its single read port, one
// slot per cycle; a drain state follows, then the result is registered
// once the result register is free. A read registers the slot's data,
// then its result once the result register is free. In both cases the
// next item can be taken in the cycle after the result is registered.
// A waiting result does not block new items; only an item that itself
// produces a result waits while the receiver stalls and the result
// register is still full. After reset the table is empty, the sequence
// is zero, recording is off, and req_ready goes high once reset is released.
`default_nettype none

module control_command_deframer_with_capture #(
   parameter int SLOTS = ccdc_pkg::DEFAULT_SLOTS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_mode,
   input  wire logic [7:0]  req_byte_value,
   input  wire logic        req_last_byte,
   input  wire logic [5:0]  req_slot_select,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_report_kind,
   output logic [5:0]       rsp_slot_index,
   output logic             rsp_slot_used,
   output logic [7:0]       rsp_command_code,
   output logic [7:0]       rsp_category_code,
   output logic [7:0]       rsp_parameter_code,
   output logic [7:0]       rsp_type_code,
   output logic [7:0]       rsp_operation_code,
   output logic [31:0]      rsp_hit_count,
   output logic [31:0]      rsp_last_seen,
   output logic             rsp_recording,
   output logic             rsp_transport_update
);

   ccdc_pkg::ctrl_cmd_type    cmd;
   ccdc_pkg::ctrl_status_type status;
   ccdc_pkg::rsp_type         rsp;

   // Sequencer.
   ccdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Framing, table and result register.
   ccdc_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_mode        (req_mode),
      .req_byte_value  (req_byte_value),
      .req_last_byte   (req_last_byte),
      .req_slot_select (req_slot_select),
      .cmd             (cmd),
      .status          (status),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp             (rsp)
   );

   // Result fields onto the ports.
   assign rsp_report_kind      = rsp.kind;
   assign rsp_slot_index       = rsp.slot;
   assign rsp_slot_used        = rsp.used;
   assign rsp_command_code     = rsp.key.command;
   assign rsp_category_code    = rsp.key.category;
   assign rsp_parameter_code   = rsp.key.parameter_code;
   assign rsp_type_code        = rsp.key.dtype;
   assign rsp_operation_code   = rsp.key.operation;
   assign rsp_hit_count        = rsp.hit_count;
   assign rsp_last_seen        = rsp.last_seen;
   assign rsp_recording        = rsp.recording;
   assign rsp_transport_update = rsp.xport;

endmodule

`default_nettype wire
